[rtl/qlu_pkg.sv]
// Shared types, codes and a helper function of the Q-learning table update block.
package qlu_pkg;

  // Field widths of the request and result items.
  localparam int Q_W    = 24;
  localparam int LR_W   = 16;
  localparam int ZB_W   = 12;
  localparam int S_W    = 8;
  localparam int A_W    = 3;
  localparam int REQ_W  = 2;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  localparam int DEF_NUM_STATES  = 256;
  localparam int DEF_NUM_ACTIONS = 8;

  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ZERO_BAND  = 2'd2;

  localparam logic [LR_W-1:0] RST_LEARN_RATE = 16'd6554;
  localparam logic [LR_W-1:0] RST_DISCOUNT   = 16'd58982;
  localparam logic [ZB_W-1:0] RST_ZERO_BAND  = 12'd1;

  typedef struct packed {
    logic [LR_W-1:0] learn_rate;
    logic [LR_W-1:0] discount;
    logic [ZB_W-1:0] zero_band;
  } qlu_cfg_t;

  // Operands of one update; all Q11.12 two's complement.
  typedef struct packed {
    logic [Q_W-1:0] reward;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] bval;
  } qlu_op_t;

  typedef struct packed {
    logic           done;
    logic           sat;
    logic [Q_W-1:0] value;
  } qlu_res_t;

  // Values whose magnitude is at most zb are stored as zero.
  function automatic logic [Q_W-1:0] band(input logic [Q_W-1:0] v, input logic [ZB_W-1:0] zb);
    logic signed [Q_W:0] ve;
    logic signed [Q_W:0] mag;
    ve  = {v[Q_W-1], v};
    mag = ve[Q_W] ? -ve : ve;
    return ($unsigned(mag) <= (Q_W+1)'(zb)) ? '0 : v;
  endfunction

endpackage

[rtl/qlu_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module qlu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/qlu_arith.sv]
// Four-stage update datapath: Q + round(alpha * (r + gamma*max - Q)), saturated and banded.
module qlu_arith import qlu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  qlu_cfg_t cfg,
  input  qlu_op_t  op,
  output qlu_res_t res
);

  localparam int FRAC  = 16;
  localparam int SHR   = 32;
  localparam int M1_W  = Q_W + LR_W + 1;
  localparam int D_W   = M1_W + 1;
  localparam int P_W   = D_W + LR_W + 2;
  localparam int INC_W = P_W - SHR;
  localparam int NV_W  = INC_W + 1;
  localparam logic signed [NV_W-1:0] NV_MAX = NV_W'((64'sd1 <<< (Q_W-1)) - 64'sd1);
  localparam logic signed [NV_W-1:0] NV_MIN = -NV_MAX - NV_W'(1);

  logic [3:0]              vld_r;
  logic signed [M1_W-1:0]  m1_r;
  logic signed [D_W-1:0]   d_r;
  logic signed [P_W-1:0]   p_r;
  logic [Q_W-1:0]          value_r;
  logic                    sat_r;

  logic signed [M1_W-1:0]  m1_nxt;
  logic signed [D_W-1:0]   d_nxt;
  logic signed [P_W-1:0]   p_nxt;
  logic signed [INC_W-1:0] inc;
  logic signed [NV_W-1:0]  nv;
  logic signed [Q_W-1:0]   clip;
  logic                    sat_nxt;

  always_comb begin
    m1_nxt = M1_W'($signed({1'b0, cfg.discount})) * M1_W'($signed(op.bval));
    d_nxt  = (D_W'($signed(op.reward)) <<< FRAC) + D_W'(m1_r)
           - (D_W'($signed(op.q)) <<< FRAC);
    p_nxt  = P_W'($signed({1'b0, cfg.learn_rate})) * P_W'(d_r)
           + (P_W'(1) <<< (SHR-1));
    // Arithmetic shift of the rounded product gives the floor.
    inc    = p_r[P_W-1:SHR];
    nv     = NV_W'($signed(op.q)) + NV_W'(inc);
    sat_nxt = 1'b1;
    if (nv > NV_MAX) begin
      clip = Q_W'(NV_MAX);
    end else if (nv < NV_MIN) begin
      clip = Q_W'(NV_MIN);
    end else begin
      clip    = Q_W'(nv);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= m1_nxt;
    d_r     <= d_nxt;
    p_r     <= p_nxt;
    value_r <= band(clip, cfg.zero_band);
    sat_r   <= sat_nxt;
  end

  assign res.done  = vld_r[3];
  assign res.sat   = sat_r;
  assign res.value = value_r;

endmodule

[rtl/q_learning_table_update.sv]
// Top level of the Q-learning table update block.
// The Q table (NUM_STATES*NUM_ACTIONS entries of signed Q11.12) sits in one RAM with
// one read and one write port. After reset the block sweeps all entries to zero, one
// entry a cycle (2048 entries at the defaults), before in_tready rises. Requests are
// handled one at a time; the read port sets the pace, since a row scan reads one action
// per cycle. Before out_tvalid rises, an update scans the successor row, reads the entry,
// runs the four-stage multiply datapath and writes back; a greedy query scans the row, a
// write writes the entry and a read fetches it. The next request is taken from the cycle
// after the result enters the output register, even if the result is not yet taken, so
// a new update is accepted only once the last one has reached the output register.
// State and action indices wrap modulo NUM_STATES and NUM_ACTIONS.
module q_learning_table_update import qlu_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // state_idx[7:0], action_idx[10:8], reward[34:11], succ_state[42:35],
  // write_value[66:43], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // greedy_act[2:0], best_value[26:3], entry_value[50:27], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // saturated[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_DW-1:0]     cfg_wdata
);

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
  localparam logic [CNT_W-1:0]  CNT_ENTRY = CNT_W'(NUM_ACTIONS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_IDX   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_SWAIT = 3'd4;
  localparam logic [2:0] ST_ARITH = 3'd5;
  localparam logic [2:0] ST_WR    = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Reduces a narrow index modulo m by restoring subtraction, one bit per step.
  function automatic logic [S_W-1:0] mod_by(input logic [S_W-1:0] x, input int unsigned m);
    logic [S_W-1:0] r;
    int unsigned    sub;
    r = x;
    for (int k = S_W - 1; k >= 0; k--) begin
      sub = m << k;
      if (sub < (32'd1 << S_W) && 32'(r) >= sub) begin
        r = r - S_W'(sub);
      end
    end
    return r;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  cnt_r, last_r;
  logic              rd_pend_r;
  logic [CNT_W-1:0]  rd_tag_r;
  logic              start_r;
  logic              out_tvalid_r;
  qlu_cfg_t          cfg_r;

  logic [REQ_W-1:0]  req_r;
  logic [S_W-1:0]    st_r, ns_r;
  logic [A_W-1:0]    act_r;
  logic [Q_W-1:0]    rew_r, wv_r;
  logic [ADDR_W-1:0] entry_addr_r, row_base_r;
  logic [A_W-1:0]    best_act_r;
  logic [Q_W-1:0]    best_val_r, q_r, entry_r;
  logic              sat_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic              out_tuser_r;

  logic              accept, load_out;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [Q_W-1:0]    ram_wdata, ram_rdata;
  logic [S_W-1:0]    s_red, a_red, ns_red;
  logic [Q_W-1:0]    wr_val, entry_out;
  qlu_op_t           op;
  qlu_res_t          res;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign load_out   = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign s_red  = mod_by(st_r, NUM_STATES);
  assign ns_red = mod_by(ns_r, NUM_STATES);
  assign a_red  = mod_by(S_W'(act_r), NUM_ACTIONS);
  assign wr_val = band(wv_r, cfg_r.zero_band);
  assign entry_out = (req_r == REQ_READ) ? q_r : entry_r;

  assign op.reward = rew_r;
  assign op.q      = q_r;
  assign op.bval   = best_val_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_addr_r;
    ram_wdata = res.value;
    ram_raddr = (cnt_r == CNT_ENTRY) ? entry_addr_r : row_base_r + ADDR_W'(cnt_r);
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        state_nxt = (req_r == REQ_WRITE) ? ST_WR : ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == last_r) begin
          state_nxt = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        state_nxt = (req_r == REQ_UPDATE) ? ST_ARITH : ST_DONE;
      end
      ST_ARITH: begin
        if (res.done) begin
          ram_we    = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = wr_val;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_addr_r   <= '0;
      rd_pend_r    <= 1'b0;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      cfg_r        <= '{learn_rate: RST_LEARN_RATE, discount: RST_DISCOUNT,
                        zero_band: RST_ZERO_BAND};
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_SCAN);
      start_r   <= (state_r == ST_SWAIT) && (req_r == REQ_UPDATE);
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LEARN_RATE: cfg_r.learn_rate <= cfg_wdata[LR_W-1:0];
          CFG_DISCOUNT:   cfg_r.discount   <= cfg_wdata[LR_W-1:0];
          CFG_ZERO_BAND:  cfg_r.zero_band  <= cfg_wdata[ZB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request payload and scan datapath.
  always_ff @(posedge clk) begin
    rd_tag_r <= cnt_r;
    if (accept) begin
      req_r      <= in_tuser;
      st_r       <= in_tdata[7:0];
      act_r      <= in_tdata[10:8];
      rew_r      <= in_tdata[34:11];
      ns_r       <= in_tdata[42:35];
      wv_r       <= in_tdata[66:43];
      best_act_r <= '0;
      best_val_r <= '0;
      entry_r    <= '0;
      sat_r      <= 1'b0;
    end
    if (state_r == ST_IDX) begin
      entry_addr_r <= ADDR_W'(s_red) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a_red);
      row_base_r   <= ((req_r == REQ_UPDATE) ? ADDR_W'(ns_red) : ADDR_W'(s_red))
                    * ADDR_W'(NUM_ACTIONS);
      // A read fetches only the entry; a query scans only the row.
      cnt_r  <= (req_r == REQ_READ) ? CNT_ENTRY : '0;
      last_r <= (req_r == REQ_QUERY) ? CNT_ENTRY - CNT_W'(1) : CNT_ENTRY;
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (rd_pend_r) begin
      if (rd_tag_r == CNT_ENTRY) begin
        q_r <= ram_rdata;
      end else if (rd_tag_r == '0 || $signed(ram_rdata) > $signed(best_val_r)) begin
        // Strict compare keeps the lowest action on ties.
        best_val_r <= ram_rdata;
        best_act_r <= A_W'(rd_tag_r);
      end
    end
    if (state_r == ST_ARITH && res.done) begin
      entry_r <= res.value;
      sat_r   <= res.sat;
    end
    if (state_r == ST_WR) begin
      entry_r <= wr_val;
    end
    if (load_out) begin
      out_tdata_r <= {(OUT_DATA_W - A_W - 2*Q_W)'(0), entry_out, best_val_r, best_act_r};
      out_tuser_r <= sat_r;
    end
  end

  qlu_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qlu_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .cfg   (cfg_r),
    .op    (op),
    .res   (res)
  );

  // One request at a time: an accepted request closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("request accepted while another is in flight");

  // The table is only written by the clearing sweep, a write request or an update.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_WR || state_r == ST_ARITH))
    else $error("table written outside a write phase");

  // A scan read never lands after its request has moved past the scan.
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN || state_r == ST_SWAIT))
    else $error("scan read data arrived outside the scan");

  // The update datapath finishes only while an update waits for it.
  a_arith_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == ST_ARITH && req_r == REQ_UPDATE))
    else $error("update result without a pending update");

endmodule
